### hdl/json_string_unescape_utf8_defines.svh
// ----------------------------------------------------------------------------
// JSON string unescaper: assertion macros
// Shared assertion helpers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define JSU_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// Implication checked in the same cycle.
`define JSU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define JSU_ASSERT(lbl, expr, msg)
`define JSU_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

### hdl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// JSON string unescaper: package
// Item types, command format between front and back, and the shared codes.
// ----------------------------------------------------------------------------
`default_nettype none
package jsu_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam logic [23:0] MAX_BYTES_RESET = 24'd1048576;

	// Input operations.
	localparam logic [1:0] OP_BEGIN = 2'd0;
	localparam logic [1:0] OP_DATA  = 2'd1;
	localparam logic [1:0] OP_END   = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Error codes.
	localparam logic [3:0] ERR_NONE       = 4'd0;
	localparam logic [3:0] ERR_CTRL       = 4'd1;
	localparam logic [3:0] ERR_ESC_SHORT  = 4'd2;
	localparam logic [3:0] ERR_BAD_ESC    = 4'd3;
	localparam logic [3:0] ERR_HEX_SHORT  = 4'd4;
	localparam logic [3:0] ERR_NON_HEX    = 4'd5;
	localparam logic [3:0] ERR_NO_LOW     = 4'd6;
	localparam logic [3:0] ERR_BAD_LOW    = 4'd7;
	localparam logic [3:0] ERR_LONE_LOW   = 4'd8;
	localparam logic [3:0] ERR_LIMIT      = 4'd9;
	localparam logic [3:0] ERR_BAD_UTF8   = 4'd10;
	localparam logic [3:0] ERR_UNTERM     = 4'd11;

	// Configuration register addresses.
	localparam logic [1:0] REG_MAX_BYTES = 2'd0;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic [3:0] error_code;
		logic       last;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_BEGIN = 2'd0,
		CMD_BYTES = 2'd1,
		CMD_CLOSE = 2'd2,
		CMD_ERROR = 2'd3
	} cmd_op_t;

	// One decoded action: a new string, a code point of one to four bytes,
	// a closing quote, or an error.
	typedef struct packed {
		cmd_op_t         op;
		logic [3:0][7:0] bytes;
		logic [1:0]      nlast;
		logic [3:0]      err;
	} cmd_t;

endpackage
`default_nettype wire

### hdl/jsu_front.sv
// ----------------------------------------------------------------------------
// JSON string unescaper: front end
// Runs the escape parser and byte limit on each accepted item and turns it
// into at most one command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module jsu_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire jsu_pkg::in_item_t item,
	input  wire logic [23:0]      max_bytes,
	output jsu_pkg::cmd_t          cmd,
	output logic                  cmd_valid
);
	import jsu_pkg::*;

	typedef enum logic [6:0] {
		MODE_IDLE  = 7'b0000001,
		MODE_PLAIN = 7'b0000010,
		MODE_ESC   = 7'b0000100,
		MODE_HEX1  = 7'b0001000,
		MODE_BSL   = 7'b0010000,
		MODE_WANTU = 7'b0100000,
		MODE_HEX2  = 7'b1000000
	} mode_t;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Bit 4 set marks a byte that is not a hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = {1'b0, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			v = {1'b0, c[3:0] + 4'd9};
		end
		return v;
	endfunction

	mode_t       mode_q, mode_d;
	logic [15:0] acc_q, acc_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [9:0]  hs_q, hs_d;
	logic [24:0] dcnt_q, dcnt_d;

	logic [7:0]      b;
	logic [4:0]      hv;
	logic [15:0]     acc_sh;
	logic [20:0]     cp;
	logic [3:0][7:0] enc_bytes;
	logic [1:0]      enc_nlast;
	logic            err_req;
	logic [3:0]      err_code;
	logic            em_req;
	logic            em_hex;
	logic [7:0]      em_one;
	logic [3:0][7:0] em_bytes;
	logic [1:0]      em_nlast;
	logic [24:0]     dcnt_sum;

	assign b      = item.data_byte;
	assign hv     = hex_value(b);
	assign acc_sh = {acc_q[11:0], hv[3:0]};
	assign cp     = (mode_q == MODE_HEX2) ?
		21'h10000 + {1'b0, hs_q, acc_sh[9:0]} : {5'd0, acc_sh};

	always_comb begin
		enc_bytes = '0;
		if (cp <= 21'h7F) begin
			enc_bytes[0] = cp[7:0];
			enc_nlast    = 2'd0;
		end else if (cp <= 21'h7FF) begin
			enc_bytes[0] = {3'b110, cp[10:6]};
			enc_bytes[1] = {2'b10, cp[5:0]};
			enc_nlast    = 2'd1;
		end else if (cp <= 21'hFFFF) begin
			enc_bytes[0] = {4'b1110, cp[15:12]};
			enc_bytes[1] = {2'b10, cp[11:6]};
			enc_bytes[2] = {2'b10, cp[5:0]};
			enc_nlast    = 2'd2;
		end else begin
			enc_bytes[0] = {5'b11110, cp[20:18]};
			enc_bytes[1] = {2'b10, cp[17:12]};
			enc_bytes[2] = {2'b10, cp[11:6]};
			enc_bytes[3] = {2'b10, cp[5:0]};
			enc_nlast    = 2'd3;
		end
	end

	assign em_bytes = em_hex ? enc_bytes : {24'd0, em_one};
	assign em_nlast = em_hex ? enc_nlast : 2'd0;
	assign dcnt_sum = dcnt_q + 25'({1'b0, em_nlast}) + 25'd1;

	always_comb begin
		mode_d    = mode_q;
		acc_d     = acc_q;
		cnt_d     = cnt_q;
		hs_d      = hs_q;
		dcnt_d    = dcnt_q;
		cmd       = '0;
		cmd_valid = 1'b0;
		err_req   = 1'b0;
		err_code  = ERR_NONE;
		em_req    = 1'b0;
		em_hex    = 1'b0;
		em_one    = b;
		if (accept) begin
			unique case (item.operation)
				OP_BEGIN: begin
					mode_d    = MODE_PLAIN;
					acc_d     = '0;
					cnt_d     = '0;
					hs_d      = '0;
					dcnt_d    = '0;
					cmd_valid = 1'b1;
					cmd.op    = CMD_BEGIN;
				end
				OP_END: begin
					unique case (mode_q)
						MODE_PLAIN: begin
							err_req  = 1'b1;
							err_code = ERR_UNTERM;
						end
						MODE_ESC: begin
							err_req  = 1'b1;
							err_code = ERR_ESC_SHORT;
						end
						MODE_BSL, MODE_WANTU: begin
							err_req  = 1'b1;
							err_code = ERR_NO_LOW;
						end
						MODE_HEX1, MODE_HEX2: begin
							err_req  = 1'b1;
							err_code = ERR_HEX_SHORT;
						end
						default: ;
					endcase
				end
				OP_DATA: begin
					unique case (mode_q)
						MODE_PLAIN: begin
							if (b == CH_QUOTE) begin
								mode_d    = MODE_IDLE;
								cmd_valid = 1'b1;
								cmd.op    = CMD_CLOSE;
							end else if (b < CH_SPACE) begin
								err_req  = 1'b1;
								err_code = ERR_CTRL;
							end else if (b == CH_BSL) begin
								mode_d = MODE_ESC;
							end else begin
								em_req = 1'b1;
							end
						end
						MODE_ESC: begin
							mode_d = MODE_PLAIN;
							em_req = 1'b1;
							unique case (b)
								CH_QUOTE, CH_BSL, CH_SLASH: em_one = b;
								CH_B: em_one = 8'h08;
								CH_F: em_one = 8'h0C;
								CH_N: em_one = 8'h0A;
								CH_R: em_one = 8'h0D;
								CH_T: em_one = 8'h09;
								CH_U: begin
									em_req = 1'b0;
									mode_d = MODE_HEX1;
									acc_d  = '0;
									cnt_d  = '0;
								end
								default: begin
									em_req   = 1'b0;
									err_req  = 1'b1;
									err_code = ERR_BAD_ESC;
								end
							endcase
						end
						MODE_BSL: begin
							if (b != CH_BSL) begin
								err_req  = 1'b1;
								err_code = ERR_NO_LOW;
							end else begin
								mode_d = MODE_WANTU;
							end
						end
						MODE_WANTU: begin
							if (b != CH_U) begin
								err_req  = 1'b1;
								err_code = ERR_NO_LOW;
							end else begin
								mode_d = MODE_HEX2;
								acc_d  = '0;
								cnt_d  = '0;
							end
						end
						MODE_HEX1, MODE_HEX2: begin
							if (hv[4]) begin
								err_req  = 1'b1;
								err_code = ERR_NON_HEX;
							end else begin
								acc_d = acc_sh;
								if (cnt_q != 2'd3) begin
									cnt_d = cnt_q + 2'd1;
								end else begin
									cnt_d = '0;
									if (mode_q == MODE_HEX1) begin
										// High surrogate: wait for the low half.
										if (acc_sh[15:10] == 6'b110110) begin
											hs_d   = acc_sh[9:0];
											mode_d = MODE_BSL;
										end else if (acc_sh[15:10] == 6'b110111) begin
											err_req  = 1'b1;
											err_code = ERR_LONE_LOW;
										end else begin
											mode_d = MODE_PLAIN;
											em_req = 1'b1;
											em_hex = 1'b1;
										end
									end else if (acc_sh[15:10] != 6'b110111) begin
										err_req  = 1'b1;
										err_code = ERR_BAD_LOW;
									end else begin
										mode_d = MODE_PLAIN;
										em_req = 1'b1;
										em_hex = 1'b1;
									end
								end
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase

			// A code point that would pass the limit is replaced by the error.
			if (em_req) begin
				if (dcnt_sum > {1'b0, max_bytes}) begin
					err_req  = 1'b1;
					err_code = ERR_LIMIT;
				end else begin
					dcnt_d    = dcnt_sum;
					cmd_valid = 1'b1;
					cmd.op    = CMD_BYTES;
					cmd.bytes = em_bytes;
					cmd.nlast = em_nlast;
				end
			end
			if (err_req) begin
				mode_d    = MODE_IDLE;
				cmd_valid = 1'b1;
				cmd.op    = CMD_ERROR;
				cmd.err   = err_code;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			acc_q  <= '0;
			cnt_q  <= '0;
			hs_q   <= '0;
			dcnt_q <= '0;
		end else begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			cnt_q  <= cnt_d;
			hs_q   <= hs_d;
			dcnt_q <= dcnt_d;
		end
	end

endmodule
`default_nettype wire

### hdl/jsu_queue.sv
// ----------------------------------------------------------------------------
// JSON string unescaper: command queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "json_string_unescape_utf8_defines.svh"
module jsu_queue #(
	parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire jsu_pkg::cmd_t wr_cmd,
	input  wire logic          rd_en,
	output jsu_pkg::cmd_t      head,
	output logic               full,
	output logic               empty
);
	import jsu_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	cmd_t            mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = (count_q == CntW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
		return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CntW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	`JSU_ASSERT(a_queue_bound, count_q <= CntW'(DEPTH), "queue count beyond depth")
	`JSU_ASSERT_IMP(a_queue_no_underrun, rd_en, !empty, "read from empty queue")
	`JSU_ASSERT_IMP(a_queue_no_overrun, wr_en, !full, "write to full queue")

endmodule
`default_nettype wire

### hdl/jsu_back.sv
// ----------------------------------------------------------------------------
// JSON string unescaper: back end
// Plays out each command one result beat per cycle while the output register
// is free or popped, and checks the decoded UTF-8 at the closing quote.
// ----------------------------------------------------------------------------
`default_nettype none
`include "json_string_unescape_utf8_defines.svh"
module jsu_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire jsu_pkg::cmd_t head,
	input  wire logic          head_valid,
	output logic               rd_en,
	output jsu_pkg::out_item_t result,
	output logic               empty,
	input  wire logic          pop
);
	import jsu_pkg::*;

	logic [1:0]  idx_q, idx_d;
	logic [1:0]  pend_q, pend_d;
	logic [20:0] part_q, part_d;
	logic [1:0]  cls_q, cls_d;
	logic        bad_q, bad_d;
	out_item_t   out_q;
	logic        out_valid_q;

	logic        can_out;
	logic        take;
	out_item_t   res;
	logic [7:0]  cb;
	logic [20:0] part_sh;
	logic [20:0] minimum;

	assign can_out = !out_valid_q || pop;
	assign cb      = head.bytes[idx_q];
	assign part_sh = {part_q[14:0], cb[5:0]};
	assign minimum = (cls_q == 2'd1) ? 21'h80 : ((cls_q == 2'd2) ? 21'h800 : 21'h10000);

	always_comb begin
		rd_en  = 1'b0;
		take   = 1'b0;
		res    = '0;
		idx_d  = idx_q;
		pend_d = pend_q;
		part_d = part_q;
		cls_d  = cls_q;
		bad_d  = bad_q;
		if (head_valid) begin
			unique case (head.op)
				CMD_BEGIN: begin
					rd_en  = 1'b1;
					pend_d = '0;
					part_d = '0;
					cls_d  = '0;
					bad_d  = 1'b0;
				end
				CMD_BYTES: begin
					if (can_out) begin
						take         = 1'b1;
						res.kind     = KIND_BYTE;
						res.out_byte = cb;
						res.last     = (idx_q == head.nlast);
						if (idx_q == head.nlast) begin
							rd_en = 1'b1;
							idx_d = '0;
						end else begin
							idx_d = idx_q + 2'd1;
						end
						// Incremental UTF-8 check, one byte per beat.
						if (pend_q == 2'd0) begin
							if (cb[7]) begin
								if (cb[7:5] == 3'b110) begin
									pend_d = 2'd1;
									part_d = {16'd0, cb[4:0]};
									cls_d  = 2'd1;
								end else if (cb[7:4] == 4'b1110) begin
									pend_d = 2'd2;
									part_d = {17'd0, cb[3:0]};
									cls_d  = 2'd2;
								end else if (cb[7:3] == 5'b11110) begin
									pend_d = 2'd3;
									part_d = {18'd0, cb[2:0]};
									cls_d  = 2'd3;
								end else begin
									bad_d = 1'b1;
								end
							end
						end else if (cb[7:6] != 2'b10) begin
							bad_d  = 1'b1;
							pend_d = '0;
						end else begin
							part_d = part_sh;
							pend_d = pend_q - 2'd1;
							if (pend_q == 2'd1 && (part_sh < minimum || part_sh > 21'h10FFFF ||
								(part_sh >= 21'hD800 && part_sh <= 21'hDFFF))) begin
								bad_d = 1'b1;
							end
						end
					end
				end
				CMD_CLOSE: begin
					if (can_out) begin
						take     = 1'b1;
						rd_en    = 1'b1;
						res.last = 1'b1;
						if (bad_q || pend_q != 2'd0) begin
							res.kind       = KIND_ERROR;
							res.error_code = ERR_BAD_UTF8;
						end else begin
							res.kind = KIND_CLOSE;
						end
					end
				end
				CMD_ERROR: begin
					if (can_out) begin
						take           = 1'b1;
						rd_en          = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = head.err;
						res.last       = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			pend_q      <= '0;
			part_q      <= '0;
			cls_q       <= '0;
			bad_q       <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			idx_q  <= idx_d;
			pend_q <= pend_d;
			part_q <= part_d;
			cls_q  <= cls_d;
			bad_q  <= bad_d;
		end
	end

	assign result = out_q;
	assign empty  = !out_valid_q;

	`JSU_ASSERT_IMP(a_idx_in_cmd, idx_q != 2'd0,
		head_valid && head.op == CMD_BYTES && idx_q <= head.nlast,
		"byte index outside the current code point")

endmodule
`default_nettype wire

### hdl/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// JSON string unescaper with UTF-8 check
// Top level: configuration register, front end, command queue and back end.
// ----------------------------------------------------------------------------
// The block takes one input item per cycle whenever full is low. The front end
// handles each item in its cycle of acceptance and writes at most one command
// into a four-entry queue; the back end drains that queue, giving one result
// beat per cycle into the output register while that register is free or
// popped. The first result of an item passes the queue and then the output
// register before it can be popped. A \u escape yields up to four bytes against
// the six or twelve input items that produce them, so the back end keeps up
// with one item per cycle; full rises only when the consumer stops popping. A
// string start is consumed by the back end but gives no result. The byte limit
// register sits at address 0 of the register port.
`default_nettype none
module json_string_unescape_utf8 #(
	parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire jsu_pkg::in_item_t  item,
	output logic                    empty,
	input  wire logic               pop,
	output jsu_pkg::out_item_t      result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [1:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import jsu_pkg::*;

	logic [23:0] max_bytes_q;
	logic        accept;
	cmd_t        cmd;
	logic        cmd_valid;
	cmd_t        head;
	logic        q_empty;
	logic        rd_en;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_MAX_BYTES) ? {8'd0, max_bytes_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= MAX_BYTES_RESET;
		end else if (psel && penable && pwrite && pready && paddr == REG_MAX_BYTES) begin
			max_bytes_q <= pwdata[23:0];
		end
	end

	assign accept = push && !full;

	jsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.max_bytes (max_bytes_q),
		.cmd       (cmd),
		.cmd_valid (cmd_valid)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept && cmd_valid),
		.wr_cmd (cmd),
		.rd_en  (rd_en),
		.head   (head),
		.full   (full),
		.empty  (q_empty)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!q_empty),
		.rd_en      (rd_en),
		.result     (result),
		.empty      (empty),
		.pop        (pop)
	);

endmodule
`default_nettype wire

### verif/json_string_unescape_utf8_tb.sv
// ----------------------------------------------------------------------------
// JSON string unescaper: testbench
// Sends directed and random string bodies through the queue-style input. The
// random bodies are mostly well-formed text, raw UTF-8, simple escapes and \u
// escapes, with errors and noise mixed in. A behavioural model predicts every
// result beat, and a monitor compares the popped beats field by field. The
// byte limit register is rewritten between phases while the block is idle,
// and the phases use varying patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module json_string_unescape_utf8_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import jsu_pkg::*;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASE_ITEMS   = 56;

	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_PLAIN,
		MODE_ESC,
		MODE_HEX1,
		MODE_BSL,
		MODE_WANTU,
		MODE_HEX2
	} decode_mode_t;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        push    = 1'b0;
	logic        full;
	in_item_t    item    = '0;
	logic        empty;
	logic        pop     = 1'b0;
	out_item_t   result;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [1:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	json_string_unescape_utf8 u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #1 clk = ~clk;

	in_item_t  pending_items[$];
	out_item_t expected_beats[$];
	out_item_t want_beat;
	int        send_idle_pct  = 0;
	int        recv_stall_pct = 0;
	int        error_count    = 0;
	int        phase_count    = 0;
	int        cycle_count    = 0;

	// Model state of the decoder.
	logic [23:0]  max_bytes  = MAX_BYTES_RESET;
	decode_mode_t dec_mode   = MODE_IDLE;
	logic [15:0]  hex_acc    = '0;
	logic [1:0]   hex_cnt    = '0;
	logic [9:0]   hi_bits    = '0;
	logic [24:0]  byte_count = '0;
	logic [1:0]   u8_pending = '0;
	logic [20:0]  u8_partial = '0;
	logic [1:0]   u8_class   = '0;
	logic         u8_bad     = 1'b0;

	function automatic logic [4:0] hex_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") return 5'(c - "0");
		if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
		if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
		return 5'd16;
	endfunction

	function automatic logic [3:0][7:0] utf8_encode(input logic [20:0] cp, output int n);
		logic [3:0][7:0] enc;
		enc = '0;
		if (cp <= 21'h7F) begin
			enc[0] = cp[7:0];
			n = 1;
		end else if (cp <= 21'h7FF) begin
			enc[0] = {3'b110, cp[10:6]};
			enc[1] = {2'b10, cp[5:0]};
			n = 2;
		end else if (cp <= 21'hFFFF) begin
			enc[0] = {4'b1110, cp[15:12]};
			enc[1] = {2'b10, cp[11:6]};
			enc[2] = {2'b10, cp[5:0]};
			n = 3;
		end else begin
			enc[0] = {5'b11110, cp[20:18]};
			enc[1] = {2'b10, cp[17:12]};
			enc[2] = {2'b10, cp[11:6]};
			enc[3] = {2'b10, cp[5:0]};
			n = 4;
		end
		return enc;
	endfunction

	task automatic raise_error(input logic [3:0] code);
		dec_mode = MODE_IDLE;
		expected_beats.insert(expected_beats.size(),
			out_item_t'{KIND_ERROR, 8'h00, code, 1'b1});
	endtask

	// Incremental UTF-8 check of everything sent out; the verdict is sticky.
	task automatic track_utf8(input logic [7:0] b);
		logic [20:0] floor_cp;
		if (u8_pending == 2'd0) begin
			if (b < 8'h80) return;
			if ((b & 8'hE0) == 8'hC0) begin
				u8_pending = 2'd1;
				u8_partial = 21'(b & 8'h1F);
			end else if ((b & 8'hF0) == 8'hE0) begin
				u8_pending = 2'd2;
				u8_partial = 21'(b & 8'h0F);
			end else if ((b & 8'hF8) == 8'hF0) begin
				u8_pending = 2'd3;
				u8_partial = 21'(b & 8'h07);
			end else begin
				u8_bad = 1'b1;
				return;
			end
			u8_class = u8_pending;
			return;
		end
		if ((b & 8'hC0) != 8'h80) begin
			u8_bad = 1'b1;
			u8_pending = 2'd0;
			return;
		end
		u8_partial = {u8_partial[14:0], b[5:0]};
		u8_pending--;
		if (u8_pending == 2'd0) begin
			floor_cp = (u8_class == 2'd1) ? 21'h80 : (u8_class == 2'd2) ? 21'h800 : 21'h10000;
			if (u8_partial < floor_cp || u8_partial > 21'h10FFFF ||
				(u8_partial >= 21'hD800 && u8_partial <= 21'hDFFF))
				u8_bad = 1'b1;
		end
	endtask

	// The limit is checked for a whole code point before any of its bytes.
	task automatic emit_bytes(input logic [3:0][7:0] enc, input int n);
		if (byte_count + n > max_bytes) begin
			raise_error(ERR_LIMIT);
			return;
		end
		byte_count = byte_count + 25'(n);
		for (int i = 0; i < n; i++) begin
			track_utf8(enc[i]);
			expected_beats.insert(expected_beats.size(),
				out_item_t'{KIND_BYTE, enc[i], ERR_NONE, i == n - 1});
		end
	endtask

	task automatic predict_item(input in_item_t it);
		logic [4:0]      h;
		logic [7:0]      b;
		logic [3:0][7:0] enc;
		int              n;
		b = it.data_byte;
		enc = '0;
		if (it.operation == OP_BEGIN) begin
			dec_mode   = MODE_PLAIN;
			hex_acc    = '0;
			hex_cnt    = '0;
			hi_bits    = '0;
			byte_count = '0;
			u8_pending = '0;
			u8_partial = '0;
			u8_class   = '0;
			u8_bad     = 1'b0;
			return;
		end
		if (it.operation == OP_NONE || dec_mode == MODE_IDLE) return;
		if (it.operation == OP_END) begin
			case (dec_mode)
				MODE_PLAIN: raise_error(ERR_UNTERM);
				MODE_ESC: raise_error(ERR_ESC_SHORT);
				MODE_BSL, MODE_WANTU: raise_error(ERR_NO_LOW);
				default: raise_error(ERR_HEX_SHORT);
			endcase
			return;
		end
		case (dec_mode)
			MODE_PLAIN: begin
				if (b == CH_QUOTE) begin
					dec_mode = MODE_IDLE;
					if (u8_bad || u8_pending != 2'd0)
						raise_error(ERR_BAD_UTF8);
					else
						expected_beats.insert(expected_beats.size(),
							out_item_t'{KIND_CLOSE, 8'h00, ERR_NONE, 1'b1});
				end else if (b < CH_SPACE) begin
					raise_error(ERR_CTRL);
				end else if (b == CH_BSLASH) begin
					dec_mode = MODE_ESC;
				end else begin
					enc[0] = b;
					emit_bytes(enc, 1);
				end
			end
			MODE_ESC: begin
				dec_mode = MODE_PLAIN;
				case (b)
					CH_QUOTE, CH_BSLASH, "/": enc[0] = b;
					"b": enc[0] = 8'h08;
					"f": enc[0] = 8'h0C;
					"n": enc[0] = 8'h0A;
					"r": enc[0] = 8'h0D;
					"t": enc[0] = 8'h09;
					"u": begin
						dec_mode = MODE_HEX1;
						hex_acc = '0;
						hex_cnt = '0;
						return;
					end
					default: begin
						raise_error(ERR_BAD_ESC);
						return;
					end
				endcase
				emit_bytes(enc, 1);
			end
			MODE_BSL: begin
				if (b != CH_BSLASH) raise_error(ERR_NO_LOW);
				else dec_mode = MODE_WANTU;
			end
			MODE_WANTU: begin
				if (b != "u") begin
					raise_error(ERR_NO_LOW);
				end else begin
					dec_mode = MODE_HEX2;
					hex_acc = '0;
					hex_cnt = '0;
				end
			end
			default: begin
				h = hex_value(b);
				if (h[4]) begin
					raise_error(ERR_NON_HEX);
					return;
				end
				hex_acc = {hex_acc[11:0], h[3:0]};
				if (hex_cnt < 2'd3) begin
					hex_cnt++;
					return;
				end
				hex_cnt = '0;
				if (dec_mode == MODE_HEX1) begin
					if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
						hi_bits = hex_acc[9:0];
						dec_mode = MODE_BSL;
					end else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
						raise_error(ERR_LONE_LOW);
					end else begin
						dec_mode = MODE_PLAIN;
						enc = utf8_encode({5'd0, hex_acc}, n);
						emit_bytes(enc, n);
					end
				end else if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
					raise_error(ERR_BAD_LOW);
				end else begin
					dec_mode = MODE_PLAIN;
					enc = utf8_encode(21'h10000 + {1'b0, hi_bits, hex_acc[9:0]}, n);
					emit_bytes(enc, n);
				end
			end
		endcase
	endtask

	// Stimulus helpers: the tasks append input beats to the pending queue.
	task automatic add_item(input logic [1:0] op, input logic [7:0] b);
		pending_items.insert(pending_items.size(), in_item_t'{op, b});
		phase_count++;
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) return "0" + nib;
		if ($urandom_range(1) != 0) return "a" + nib - 8'd10;
		return "A" + nib - 8'd10;
	endfunction

	task automatic add_hex_digits(input logic [15:0] v, input int count);
		for (int i = 3; i > 3 - count; i--)
			add_item(OP_DATA, hex_char(v[4*i +: 4]));
	endtask

	task automatic add_escape_u(input logic [15:0] v);
		add_item(OP_DATA, CH_BSLASH);
		add_item(OP_DATA, "u");
		add_hex_digits(v, 4);
	endtask

	function automatic logic [15:0] random_high();
		return 16'hD800 | 16'($urandom_range(10'h3FF));
	endfunction

	function automatic logic [20:0] pick_code_point();
		logic [20:0] cp;
		case ($urandom_range(3))
			0: cp = 21'($urandom_range(8'h7F));
			1: cp = 21'($urandom_range(21'h7FF, 21'h80));
			2: cp = 21'($urandom_range(21'hFFFF, 21'h800));
			default: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
		endcase
		// Surrogate code points cannot be written directly; move them aside.
		if (cp >= 21'hD800 && cp <= 21'hDFFF) cp ^= 21'h4000;
		return cp;
	endfunction

	task automatic add_code_point_escape(input logic [20:0] cp);
		logic [20:0] v;
		if (cp <= 21'hFFFF) begin
			add_escape_u(cp[15:0]);
		end else begin
			v = cp - 21'h10000;
			add_escape_u(16'hD800 | v[19:10]);
			add_escape_u(16'hDC00 | v[9:0]);
		end
	endtask

	task automatic add_string();
		logic [20:0]     cp;
		logic [3:0][7:0] enc;
		logic [7:0]      b;
		logic [4:0]      hv;
		int              n;
		int              k;
		add_item(OP_BEGIN, 8'($urandom_range(8'hFF)));
		repeat ($urandom_range(8)) begin
			case ($urandom_range(9))
				0, 1, 2: begin
					b = 8'($urandom_range(8'h7E, 8'h20));
					if (b == CH_QUOTE || b == CH_BSLASH) b = "a";
					add_item(OP_DATA, b);
				end
				3: begin
					cp = pick_code_point() | 21'h80;
					if (cp >= 21'hD800 && cp <= 21'hDFFF) cp ^= 21'h4000;
					enc = utf8_encode(cp, n);
					for (int i = 0; i < n; i++) add_item(OP_DATA, enc[i]);
				end
				4: add_item(OP_DATA, 8'($urandom_range(8'hFF, 8'h80)));
				5: begin
					add_item(OP_DATA, CH_BSLASH);
					case ($urandom_range(7))
						0: add_item(OP_DATA, CH_QUOTE);
						1: add_item(OP_DATA, CH_BSLASH);
						2: add_item(OP_DATA, "/");
						3: add_item(OP_DATA, "b");
						4: add_item(OP_DATA, "f");
						5: add_item(OP_DATA, "n");
						6: add_item(OP_DATA, "r");
						default: add_item(OP_DATA, "t");
					endcase
				end
				6, 7: add_code_point_escape(pick_code_point());
				8: begin
					// A multi-byte sequence cut short leaves the check pending.
					cp = pick_code_point() | 21'h80;
					enc = utf8_encode(cp, n);
					k = (n > 1) ? $urandom_range(n - 1, 1) : 1;
					for (int i = 0; i < k; i++) add_item(OP_DATA, enc[i]);
				end
				default: begin
					if ($urandom_range(1) != 0)
						add_item(2'($urandom_range(3)), 8'($urandom_range(8'hFF)));
					else
						add_item(OP_DATA, "x");
				end
			endcase
		end
		if ($urandom_range(99) < 70) begin
			add_item(OP_DATA, CH_QUOTE);
			return;
		end
		case ($urandom_range(7))
			0: add_item(OP_DATA, 8'($urandom_range(8'h1F)));
			1: begin
				b = 8'($urandom_range(8'hFF));
				case (b)
					CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t", "u": b = "q";
					default: ;
				endcase
				add_item(OP_DATA, CH_BSLASH);
				add_item(OP_DATA, b);
			end
			2: begin
				add_item(OP_DATA, CH_BSLASH);
				add_item(OP_DATA, "u");
				add_hex_digits(16'($urandom_range(16'hFFFF)), $urandom_range(3));
				do begin
					b = 8'($urandom_range(8'hFF));
					hv = hex_value(b);
				end while (!hv[4]);
				add_item(OP_DATA, b);
			end
			3: add_escape_u(16'hDC00 | 16'($urandom_range(10'h3FF)));
			4: begin
				add_escape_u(random_high());
				cp = 21'($urandom_range(16'hFFFF));
				if (cp >= 21'hDC00 && cp <= 21'hDFFF) cp ^= 21'h2000;
				add_escape_u(cp[15:0]);
			end
			5: begin
				add_escape_u(random_high());
				b = 8'($urandom_range(8'hFF));
				if (b == CH_BSLASH) b = "A";
				add_item(OP_DATA, b);
			end
			6: begin
				add_escape_u(random_high());
				add_item(OP_DATA, CH_BSLASH);
				b = 8'($urandom_range(8'hFF));
				if (b == "u") b = "v";
				add_item(OP_DATA, b);
			end
			default: begin
				case ($urandom_range(4))
					0: ;
					1: add_item(OP_DATA, CH_BSLASH);
					2: begin
						add_item(OP_DATA, CH_BSLASH);
						add_item(OP_DATA, "u");
						add_hex_digits(16'($urandom_range(16'hFFFF)), $urandom_range(3));
					end
					3: add_escape_u(random_high());
					default: begin
						add_escape_u(random_high());
						add_item(OP_DATA, CH_BSLASH);
					end
				endcase
				add_item(OP_END, 8'($urandom_range(8'hFF)));
			end
		endcase
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || push || expected_beats.size() != 0)
			@(posedge clk);
		// A string start gives no result but still occupies the back end.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_byte_limit(input logic [23:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_MAX_BYTES;
		pwdata  <= {8'h00, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		max_bytes = value;
		@(posedge clk);
		psel   <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[23:0] !== value) begin
			$display("%0t: limit register readback expected %06h got %06h",
				$realtime, value, prdata[23:0]);
			error_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		phase_count    = 0;
		while (phase_count < PHASE_ITEMS) add_string();
		wait_idle();
	endtask

	// Sender: one input beat at a time, held until full is low.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) predict_item(item);
			if (!(push && full)) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item <= pending_items.pop_front();
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Receiver: compares every popped beat with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_beats.size() == 0) begin
					$display("%0t: unexpected beat kind=%0d byte=%02h err=%0d last=%0b",
						$realtime, result.kind, result.out_byte, result.error_code,
						result.last);
					error_count++;
				end else begin
					want_beat = expected_beats.pop_front();
					if (result.kind !== want_beat.kind || result.out_byte !== want_beat.out_byte ||
						result.error_code !== want_beat.error_code ||
						result.last !== want_beat.last) begin
						$display("%0t: expected kind=%0d byte=%02h err=%0d last=%0b, got kind=%0d byte=%02h err=%0d last=%0b",
							$realtime, want_beat.kind, want_beat.out_byte, want_beat.error_code,
							want_beat.last, result.kind, result.out_byte, result.error_code,
							result.last);
						error_count++;
					end
				end
			end
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle handling, ignored operation, bad UTF-8 at the quote,
		// the highest surrogate pair, a control character, restart and end.
		add_item(OP_END, 8'h00);
		add_item(OP_DATA, 8'hFF);
		add_item(OP_NONE, 8'hFF);
		add_item(OP_BEGIN, 8'h00);
		add_item(OP_DATA, 8'hFF);
		add_item(OP_DATA, CH_QUOTE);
		add_item(OP_BEGIN, 8'hFF);
		add_escape_u(16'hDBFF);
		add_escape_u(16'hDFFF);
		add_item(OP_DATA, CH_QUOTE);
		add_item(OP_BEGIN, 8'h00);
		add_item(OP_DATA, 8'h00);
		add_item(OP_BEGIN, 8'h00);
		add_item(OP_BEGIN, 8'h00);
		add_item(OP_END, 8'h00);
		wait_idle();

		run_phase(0, 0);
		set_byte_limit(24'hFFFFFF);
		run_phase(52, 0);
		set_byte_limit(24'h000000);
		run_phase(0, 52);
		set_byte_limit(24'($urandom_range(24, 2)));
		run_phase(38, 38);
		set_byte_limit(24'($urandom_range(60, 4)));
		run_phase(0, 0);
		set_byte_limit(MAX_BYTES_RESET);
		run_phase(38, 38);

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		wait_idle();
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire
